// ===== rtl/lgbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Label grid border pixels: shared package
// Types and constants used by the border pixel detector and its submodules.
// ----------------------------------------------------------------------------
package lgbp_pkg;

	// Field widths of the item payloads.
	localparam int LABEL_W = 32;
	localparam int X_W     = 12;
	localparam int Y_W     = 13;

	// Width used for the effective frame size and for compares against it.
	localparam int EFF_W = 17;

	// Configuration port.
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam logic REG_FRAME_COLUMNS = 1'b0;
	localparam logic REG_FRAME_ROWS    = 1'b1;
	localparam logic [X_W-1:0] FRAME_COLUMNS_RESET = 12'd2048;
	localparam logic [Y_W-1:0] FRAME_ROWS_RESET    = 13'd4096;

	// Result queue geometry.
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = 2;
	localparam int RQ_CW    = 3;

	// One column entry of the line stores: the row above and the row above that.
	typedef struct packed {
		logic [LABEL_W-1:0] older;
		logic [LABEL_W-1:0] prev;
	} row_pair_t;

	// One border pixel result.
	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic [X_W-1:0]     x;
		logic [Y_W-1:0]     y;
		logic               last;
	} border_t;

endpackage

// ===== rtl/lgbp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Label grid border pixels: configuration registers
// APB-style register file holding the frame size, plus the effective size
// after clamping to the range the line stores support.
// ----------------------------------------------------------------------------
module lgbp_cfg_regs #(
	parameter int MAX_COLUMNS = 2048,
	parameter int MAX_ROWS    = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lgbp_pkg::CFG_AW-1:0] paddr,
	input  logic [lgbp_pkg::CFG_DW-1:0] pwdata,
	output logic [lgbp_pkg::CFG_DW-1:0] prdata,
	output logic                        pready,
	output logic [lgbp_pkg::EFF_W-1:0]  eff_cols,
	output logic [lgbp_pkg::EFF_W-1:0]  eff_rows
);
	import lgbp_pkg::*;

	logic [X_W-1:0] frame_columns_q;
	logic [Y_W-1:0] frame_rows_q;
	logic           wr_en;
	logic           reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_columns_q <= FRAME_COLUMNS_RESET;
			frame_rows_q    <= FRAME_ROWS_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_FRAME_COLUMNS: frame_columns_q <= pwdata[X_W-1:0];
				REG_FRAME_ROWS:    frame_rows_q    <= pwdata[Y_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (reg_sel)
			REG_FRAME_COLUMNS: prdata = CFG_DW'(frame_columns_q);
			REG_FRAME_ROWS:    prdata = CFG_DW'(frame_rows_q);
			default:           prdata = '0;
		endcase
	end

	// A zero size acts as one, a size above the store limit acts as the limit.
	always_comb begin
		if (frame_columns_q == '0) begin
			eff_cols = EFF_W'(1);
		end else if (EFF_W'(frame_columns_q) > EFF_W'(MAX_COLUMNS)) begin
			eff_cols = EFF_W'(MAX_COLUMNS);
		end else begin
			eff_cols = EFF_W'(frame_columns_q);
		end
		if (frame_rows_q == '0) begin
			eff_rows = EFF_W'(1);
		end else if (EFF_W'(frame_rows_q) > EFF_W'(MAX_ROWS)) begin
			eff_rows = EFF_W'(MAX_ROWS);
		end else begin
			eff_rows = EFF_W'(frame_rows_q);
		end
	end

endmodule

// ===== rtl/lgbp_row_bank.sv =====
// ----------------------------------------------------------------------------
// Label grid border pixels: line store bank
// One parity bank of the two line stores, one write and one registered read
// per cycle. A write and a read of the same entry in one cycle return the
// new data.
// ----------------------------------------------------------------------------
module lgbp_row_bank #(
	parameter int AW = 10
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  lgbp_pkg::row_pair_t  wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output lgbp_pkg::row_pair_t  rdata
);
	import lgbp_pkg::*;

	row_pair_t mem [2**AW];
	row_pair_t rd_data_q;

	assign rdata = rd_data_q;

	// Storage with write-through on the read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

endmodule

// ===== rtl/lgbp_result_queue.sv =====
// ----------------------------------------------------------------------------
// Label grid border pixels: result queue
// Takes up to three results of one item in a cycle, packs them in order and
// hands them out one per cycle on the output stream while out_ready is high.
// ----------------------------------------------------------------------------
module lgbp_result_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [2:0]                    emit,
	input  lgbp_pkg::border_t [2:0]       cand,
	output logic                          room,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lgbp_pkg::border_t             out_item
);
	import lgbp_pkg::*;

	border_t           slots_q [RQ_DEPTH];
	logic [RQ_AW-1:0]  wptr_q;
	logic [RQ_AW-1:0]  rptr_q;
	logic [RQ_CW-1:0]  count_q;
	logic [1:0]        n_push;
	logic [RQ_AW-1:0]  pos [3];
	logic              pop;

	// Number of results and the slot offset of each one.
	assign n_push = 2'(emit[0]) + 2'(emit[1]) + 2'(emit[2]);
	assign pos[0] = '0;
	assign pos[1] = RQ_AW'(emit[0]);
	assign pos[2] = RQ_AW'(emit[0]) + RQ_AW'(emit[1]);

	assign room      = (count_q + RQ_CW'(n_push)) <= RQ_CW'(RQ_DEPTH);
	assign out_valid = count_q != '0;
	assign out_item  = slots_q[rptr_q];
	assign pop       = out_valid && out_ready;

	// Result storage.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (push && emit[k]) begin
				slots_q[RQ_AW'(wptr_q + pos[k])] <= cand[k];
			end
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + RQ_AW'(n_push);
			end
			if (pop) begin
				rptr_q <= rptr_q + RQ_AW'(1);
			end
			count_q <= count_q + (push ? RQ_CW'(n_push) : RQ_CW'(0)) - RQ_CW'(pop);
		end
	end

endmodule

// ===== rtl/label_grid_border_pixels.sv =====
// ----------------------------------------------------------------------------
// Label grid border pixels: top level
// Finds the 4-connected border pixels of a raster-order label image.
// ----------------------------------------------------------------------------
// The block takes one 32-bit label per item in raster order and reports every
// nonzero pixel that touches the frame edge or a differently labeled
// 4-neighbor, as its label and one-based column and row. A pixel is decided
// one row late, when the pixel below it arrives; in the last row a pixel is
// decided when its right neighbor arrives, and the final pixel on its own arrival,
// so an item causes zero to three results. Given room in the queue, an item is
// taken every clock: it is registered together with the line store reads issued
// at its acceptance, decided from that register and its results go into a four-entry
// queue. The output hands out one result per ready clock, so in the last row, where
// an item can give up to three results, the input follows the output rate. The two
// line stores are held as one memory of row pairs, split by column parity so that a
// row end can write two columns in one cycle; they need no clearing after reset. The
// frame size may only be changed while no item is in flight.
module label_grid_border_pixels #(
	parameter int MAX_COLUMNS = 2048,
	parameter int MAX_ROWS    = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lgbp_pkg::CFG_AW-1:0] paddr,
	input  logic [lgbp_pkg::CFG_DW-1:0] pwdata,
	output logic [lgbp_pkg::CFG_DW-1:0] prdata,
	output logic                        pready,
	// Input stream.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,   // [31:0] pixel_label
	// Output stream.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [63:0]                 m_tdata,   // [31:0] border_label,
	                                               // [43:32] border_x,
	                                               // [56:44] border_y, rest zero
	output logic                        m_tlast    // last_of_run
);
	import lgbp_pkg::*;

	localparam int XW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int YW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int BW = (XW > 1) ? XW - 1 : 1;

	logic [EFF_W-1:0]   eff_cols;
	logic [EFF_W-1:0]   eff_rows;

	// Position of the next item.
	logic [XW-1:0]      col_q;
	logic [YW-1:0]      row_q;
	logic               s_fire;
	logic               row_end_in;
	logic               last_row_in;

	// Input register stage.
	logic               valid_s1;
	logic [LABEL_W-1:0] label_s1;
	logic [XW-1:0]      col_s1;
	logic [YW-1:0]      row_s1;
	logic               row_end_s1;
	logic               last_row_s1;
	logic               s1_fire;

	// Left neighbors: row above and current row, one column back.
	logic [LABEL_W-1:0] left_q;
	logic [LABEL_W-1:0] tail_q;

	row_pair_t          rd_word [2];
	row_pair_t          center;
	row_pair_t          right_word;
	logic [XW-1:0]      left_col;
	logic               col_ge1_s1;

	logic [2:0]         emit;
	border_t [2:0]      cand;
	logic               room;
	border_t            out_item;

	lgbp_cfg_regs #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.eff_cols (eff_cols),
		.eff_rows (eff_rows)
	);

	// Handshake: the input register frees up when its item moves on.
	assign s1_fire  = valid_s1 && room;
	assign s_tready = !valid_s1 || s1_fire;
	assign s_fire   = s_tvalid && s_tready;

	assign row_end_in  = (EFF_W'(col_q) + EFF_W'(1)) >= eff_cols;
	assign last_row_in = (EFF_W'(row_q) + EFF_W'(1)) >= eff_rows;

	// Column and row counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_fire) begin
			if (row_end_in) begin
				col_q <= '0;
				row_q <= last_row_in ? '0 : row_q + YW'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	// Input register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			label_s1    <= s_tdata;
			col_s1      <= col_q;
			row_s1      <= row_q;
			row_end_s1  <= row_end_in;
			last_row_s1 <= last_row_in;
		end
	end

	assign col_ge1_s1 = col_s1 != '0;
	assign left_col   = col_s1 - XW'(1);
	assign center     = col_s1[0] ? rd_word[1] : rd_word[0];
	assign right_word = col_s1[0] ? rd_word[0] : rd_word[1];

	// Current row tail; cleared at the end of each row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= '0;
		end else if (s1_fire) begin
			tail_q <= row_end_s1 ? '0 : label_s1;
		end
	end

	// The row-above label at this column is the left neighbor of the next item.
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			left_q <= center.prev;
		end
	end

	// Line store banks. Column c-1 is retired by every item after column 0, column c
	// as well at the row end; reads fetch columns c and c+1 for the item being taken.
	for (genvar b = 0; b < 2; b++) begin : g_bank
		localparam logic BANK = 1'(b);
		logic          wr_left;
		logic          wr_cur;
		logic          we;
		logic [BW-1:0] waddr;
		logic [BW-1:0] raddr;
		logic [XW-1:0] rcol;
		row_pair_t     wdata;

		assign wr_left = col_ge1_s1 && (left_col[0] == BANK);
		assign wr_cur  = row_end_s1 && (col_s1[0] == BANK);
		assign we      = s1_fire && (wr_left || wr_cur);
		assign waddr   = wr_left ? BW'(left_col >> 1) : BW'(col_s1 >> 1);
		assign wdata   = wr_left ? row_pair_t'{older: left_q, prev: tail_q}
		                         : row_pair_t'{older: center.prev, prev: label_s1};
		assign rcol    = (col_q[0] == BANK) ? col_q : col_q + XW'(1);
		assign raddr   = BW'(rcol >> 1);

		lgbp_row_bank #(
			.AW (BW)
		) u_bank (
			.clk   (clk),
			.we    (we),
			.waddr (waddr),
			.wdata (wdata),
			.re    (s_fire),
			.raddr (raddr),
			.rdata (rd_word[b])
		);
	end

	// Border decisions: the pixel above, then in the last row the left
	// neighbor and the final pixel. Last-row pixels have no pixel below, so
	// any nonzero one is a border pixel.
	always_comb begin
		emit[0] = (row_s1 != '0) && (center.prev != '0) &&
		          ((row_s1 <= YW'(1)) || (center.older != center.prev) ||
		           row_end_s1 || (right_word.prev != center.prev) ||
		           (label_s1 != center.prev) ||
		           !col_ge1_s1 || (left_q != center.prev));
		emit[1] = last_row_s1 && col_ge1_s1 && (tail_q != '0);
		emit[2] = last_row_s1 && row_end_s1 && (label_s1 != '0);

		cand[0].label = center.prev;
		cand[0].x     = X_W'((XW+1)'(col_s1) + (XW+1)'(1));
		cand[0].y     = Y_W'(row_s1);
		cand[0].last  = !emit[1] && !emit[2];

		cand[1].label = tail_q;
		cand[1].x     = X_W'(col_s1);
		cand[1].y     = Y_W'((YW+1)'(row_s1) + (YW+1)'(1));
		cand[1].last  = !emit[2];

		cand[2].label = label_s1;
		cand[2].x     = X_W'((XW+1)'(col_s1) + (XW+1)'(1));
		cand[2].y     = Y_W'((YW+1)'(row_s1) + (YW+1)'(1));
		cand[2].last  = 1'b1;
	end

	lgbp_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_fire),
		.emit      (emit),
		.cand      (cand),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item)
	);

	// Output payload packing.
	assign m_tdata = {7'b0, out_item.y, out_item.x, out_item.label};
	assign m_tlast = out_item.last;

endmodule
